// ----- rtl/core/cpd_pkg.sv -----
// ============================================================================
// cpd_pkg: shared types and constants of the command packet deframer
// Header type codes, record kinds, draw opcodes and the record that moves
// from the parse front end to the output back end.
// ============================================================================
`default_nettype none

package cpd_pkg;

    // Defaults for the top-level parameters
    localparam int OFFSET_BITS_DEF   = 20;
    localparam int CAPTURE_WORDS_DEF = 4;

    // Fixed field widths of the record
    localparam int WORD_W     = 32;
    localparam int PKT_OFS_W  = 20;
    localparam int COUNT_W    = 15;
    localparam int OPCODE_W   = 8;
    localparam int OUT_WORDS  = 4;
    localparam int OUT_DATA_W = 208;

    // Header type, bits 31:30 of a header word
    typedef enum logic [1:0] {
        PKT_TYPE0 = 2'd0,
        PKT_TYPE1 = 2'd1,
        PKT_TYPE2 = 2'd2,
        PKT_TYPE3 = 2'd3
    } pkt_type_t;

    // Kind of an emitted record
    typedef enum logic [1:0] {
        KIND_TYPE0 = 2'd0,
        KIND_TYPE3 = 2'd1,
        KIND_CUT   = 2'd2,
        KIND_HALT  = 2'd3
    } rec_kind_t;

    // Opcodes of interest
    localparam logic [OPCODE_W-1:0] OP_DRAW_INDX      = 8'h2C;
    localparam logic [OPCODE_W-1:0] OP_DRAW_INDX_BIN  = 8'h2D;
    localparam logic [OPCODE_W-1:0] OP_DRAW_INDX_IMM  = 8'h33;
    localparam logic [OPCODE_W-1:0] OP_DRAW_INDX_2    = 8'h36;
    localparam logic [OPCODE_W-1:0] OP_DRAW_INDX_OFS  = 8'h43;

    // Parsed record handed from front to back
    typedef struct packed {
        logic [PKT_OFS_W-1:0]             packet_offset;
        rec_kind_t                        kind;
        logic                             is_type3;
        logic [OPCODE_W-1:0]              opcode;
        logic [COUNT_W-1:0]               data_count;
        logic [OUT_WORDS-1:0][WORD_W-1:0] words;
    } rec_t;

    // Parse status of the front end
    typedef struct packed {
        logic halted;
        logic in_packet;
    } front_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/command_packet_deframer_core.sv -----
// ============================================================================
// command_packet_deframer_core: command buffer packet deframer
// Splits a stream of command dwords into packets and emits one record per
// packet, per packet cut short by buffer end, and per type-1 stop header.
// ============================================================================
// Input channel s_*: one command dword per request, s_tuser marks the first
// dword of a buffer (restarts offset and parse state), s_tlast the last.
// Output channel m_*: one record per finished packet; most dwords produce
// none. Throughput is one dword per cycle while the queue has room: the
// parse front end does a header decode or one capture per dword. A record
// is pushed into a two-entry queue at the accepting edge, moves on into the
// output register once that register is free, and shows on m_tvalid from
// then on. The back end decodes the draw initiator on its way into that
// register.
// When the receiver stalls, the output register holds its record, the queue
// fills, and s_tready drops only once both queue entries are taken.
// Reset (aresetn low at a clock edge) clears the offset, parse state, queue
// and output valid; no clearing pass is needed.
// ============================================================================
`default_nettype none

module command_packet_deframer_core #(
    parameter int OFFSET_BITS   = cpd_pkg::OFFSET_BITS_DEF,
    parameter int CAPTURE_WORDS = cpd_pkg::CAPTURE_WORDS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [31:0] word
    input  wire logic [31:0]                   s_tdata,
    // [0] first_word
    input  wire logic                          s_tuser,
    input  wire logic                          s_tlast,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [19:0] packet_offset, [21:20] record_kind, [29:22] opcode,
    // [44:30] data_count, [45] draw_flag, [77:46] data_zero,
    // [109:78] data_one, [141:110] data_two, [173:142] data_three,
    // [179:174] prim_kind, [181:180] source_select, [203:182] index_total
    output logic [cpd_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import cpd_pkg::*;

    logic          s_accept;
    logic          rec_push;
    rec_t          front_rec;
    front_status_t front_st;
    logic          q_room;
    logic          q_valid;
    logic          q_pop;
    rec_t          q_rec;

    assign s_tready = q_room;
    assign s_accept = s_tvalid && s_tready;

    // Parse front end
    cpd_front #(
        .OFFSET_BITS   (OFFSET_BITS),
        .CAPTURE_WORDS (CAPTURE_WORDS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (s_accept),
        .word       (s_tdata),
        .first_word (s_tuser),
        .last_word  (s_tlast),
        .rec_push   (rec_push),
        .rec        (front_rec),
        .status     (front_st)
    );

    // Record queue
    cpd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (rec_push),
        .push_rec  (front_rec),
        .has_room  (q_room),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_rec   (q_rec)
    );

    // Output back end
    cpd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rec_valid (q_valid),
        .rec       (q_rec),
        .rec_pop   (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Halted and in-packet exclude each other
    a_state_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(front_st.halted && front_st.in_packet))
        else $error("parser both halted and inside a packet");

    // Halted parser stays silent until a new buffer starts
    a_halt_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && front_st.halted && !s_tuser) |-> !rec_push)
        else $error("record emitted while halted");

    // A cut-short record only comes with the last dword of a buffer
    a_cut_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (rec_push && front_rec.kind == KIND_CUT) |-> s_tlast)
        else $error("cut-short record without buffer end");

    // Type-0 records carry no opcode and no draw flag
    a_type0_plain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[21:20] == KIND_TYPE0) |-> (m_tdata[29:22] == '0 && !m_tdata[45]))
        else $error("type-0 record with opcode or draw flag");

endmodule

`default_nettype wire

// ----- rtl/core/cpd_front.sv -----
// ============================================================================
// cpd_front: header decode and data capture
// Tracks the parse state over the incoming dwords and builds one record
// when a packet ends, is cut short, or a type-1 header halts parsing.
// ============================================================================
`default_nettype none

module cpd_front #(
    parameter int OFFSET_BITS   = 20,
    parameter int CAPTURE_WORDS = 4
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  accept,
    input  wire logic [31:0]           word,
    input  wire logic                  first_word,
    input  wire logic                  last_word,
    output logic                       rec_push,
    output cpd_pkg::rec_t              rec,
    output cpd_pkg::front_status_t     status
);
    import cpd_pkg::*;

    localparam int IDX_W = $clog2(CAPTURE_WORDS + 1);

    logic [OFFSET_BITS-1:0]   position_reg, position_next, pos_base;
    logic                     in_packet_reg, in_packet_next, in_base;
    logic                     halted_reg, halted_next, halt_base;
    logic [COUNT_W-1:0]       words_left_reg, words_left_next, wl_base;
    logic [PKT_OFS_W-1:0]     hdr_offset_reg, hdr_offset_next;
    logic                     hdr_type3_reg, hdr_type3_next;
    logic [OPCODE_W-1:0]      hdr_opcode_reg, hdr_opcode_next;
    logic [COUNT_W-1:0]       hdr_count_reg, hdr_count_next;
    logic [WORD_W-1:0]        cap_reg [CAPTURE_WORDS];
    logic [WORD_W-1:0]        cap_next [CAPTURE_WORDS];
    logic [WORD_W-1:0]        cap_base [CAPTURE_WORDS];
    logic [IDX_W-1:0]         cap_idx_reg, cap_idx_next, idx_base;

    logic [1:0]               hdr_type;
    logic [COUNT_W-1:0]       hdr_cnt;
    logic                     pkt_emit;
    rec_kind_t                pkt_kind;
    logic                     halt_emit;

    assign hdr_type = word[31:30];
    assign hdr_cnt  = COUNT_W'(word[29:16]) + COUNT_W'(1);

    // Parse one dword
    always_comb begin
        // a new buffer restarts the offset and drops any open packet
        pos_base  = first_word ? '0 : position_reg;
        in_base   = first_word ? 1'b0 : in_packet_reg;
        halt_base = first_word ? 1'b0 : halted_reg;
        wl_base   = first_word ? '0 : words_left_reg;
        idx_base  = first_word ? '0 : cap_idx_reg;
        for (int k = 0; k < CAPTURE_WORDS; k++) begin
            cap_base[k] = first_word ? '0 : cap_reg[k];
        end

        in_packet_next  = in_base;
        halted_next     = halt_base;
        words_left_next = wl_base;
        cap_idx_next    = idx_base;
        cap_next        = cap_base;
        hdr_offset_next = hdr_offset_reg;
        hdr_type3_next  = hdr_type3_reg;
        hdr_opcode_next = hdr_opcode_reg;
        hdr_count_next  = hdr_count_reg;
        pkt_emit        = 1'b0;
        pkt_kind        = KIND_TYPE0;
        halt_emit       = 1'b0;

        if (halt_base) begin
            // stopped until the next buffer
        end else if (in_base) begin
            // capture a data dword
            for (int k = 0; k < CAPTURE_WORDS; k++) begin
                if (idx_base == IDX_W'(k)) begin
                    cap_next[k] = word;
                end
            end
            if (idx_base < IDX_W'(CAPTURE_WORDS)) begin
                cap_idx_next = idx_base + IDX_W'(1);
            end
            words_left_next = wl_base - COUNT_W'(1);
            if (words_left_next == '0) begin
                pkt_emit       = 1'b1;
                pkt_kind       = hdr_type3_reg ? KIND_TYPE3 : KIND_TYPE0;
                in_packet_next = 1'b0;
            end
        end else begin
            case (hdr_type)
                PKT_TYPE1: begin
                    halt_emit   = 1'b1;
                    halted_next = 1'b1;
                end
                PKT_TYPE2: begin
                    // filler: skip
                end
                default: begin
                    // open a type 0 or type 3 packet
                    hdr_offset_next = PKT_OFS_W'(pos_base);
                    hdr_type3_next  = (hdr_type == PKT_TYPE3);
                    hdr_opcode_next = (hdr_type == PKT_TYPE3) ? word[15:8] : '0;
                    hdr_count_next  = hdr_cnt;
                    words_left_next = hdr_cnt;
                    for (int k = 0; k < CAPTURE_WORDS; k++) begin
                        cap_next[k] = '0;
                    end
                    cap_idx_next   = '0;
                    in_packet_next = 1'b1;
                end
            endcase
        end

        // buffer end inside a packet cuts it short
        if (last_word && in_packet_next) begin
            pkt_emit        = 1'b1;
            pkt_kind        = KIND_CUT;
            in_packet_next  = 1'b0;
            words_left_next = '0;
        end

        // saturating offset
        position_next = (pos_base != '1) ? pos_base + OFFSET_BITS'(1) : pos_base;
    end

    // Build the record
    always_comb begin
        rec = '0;
        if (halt_emit) begin
            rec.packet_offset = PKT_OFS_W'(pos_base);
            rec.kind          = KIND_HALT;
            rec.data_count    = hdr_cnt;
        end else begin
            rec.packet_offset = hdr_offset_next;
            rec.kind          = pkt_kind;
            rec.is_type3      = hdr_type3_next;
            rec.opcode        = hdr_opcode_next;
            rec.data_count    = hdr_count_next;
            for (int k = 0; k < OUT_WORDS; k++) begin
                if (k < CAPTURE_WORDS) begin
                    rec.words[k] = cap_next[k];
                end
            end
        end
    end

    assign rec_push         = accept && (pkt_emit || halt_emit);
    assign status.halted    = halted_reg;
    assign status.in_packet = in_packet_reg;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg   <= '0;
            in_packet_reg  <= 1'b0;
            halted_reg     <= 1'b0;
            words_left_reg <= '0;
            cap_idx_reg    <= '0;
        end else if (accept) begin
            position_reg   <= position_next;
            in_packet_reg  <= in_packet_next;
            halted_reg     <= halted_next;
            words_left_reg <= words_left_next;
            cap_idx_reg    <= cap_idx_next;
        end
    end

    // Header and captured payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            hdr_offset_reg <= hdr_offset_next;
            hdr_type3_reg  <= hdr_type3_next;
            hdr_opcode_reg <= hdr_opcode_next;
            hdr_count_reg  <= hdr_count_next;
            cap_reg        <= cap_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/cpd_queue.sv -----
// ============================================================================
// cpd_queue: two-entry record queue
// Decouples the parse front end from the output back end so that each
// side stalls on its own.
// ============================================================================
`default_nettype none

module cpd_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  cpd_pkg::rec_t       push_rec,
    output logic                has_room,
    input  wire logic           pop,
    output logic                not_empty,
    output cpd_pkg::rec_t       pop_rec
);
    import cpd_pkg::*;

    rec_t        entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign has_room  = (count_reg != 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_rec   = entry_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store a request
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/cpd_back.sv -----
// ============================================================================
// cpd_back: record decode and output register
// Derives the draw flag and draw initiator fields from a queued record and
// holds the packed result until the receiver takes it.
// ============================================================================
`default_nettype none

module cpd_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          rec_valid,
    input  cpd_pkg::rec_t                      rec,
    output logic                               rec_pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [cpd_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import cpd_pkg::*;

    logic                  valid_reg, valid_next;
    logic [OUT_DATA_W-1:0] data_reg, data_next;
    logic [OPCODE_W-1:0]   op;
    logic                  draw;
    logic                  has_init;
    logic [WORD_W-1:0]     init;
    logic                  load;

    // Decode opcode-dependent fields
    always_comb begin
        op       = rec.is_type3 ? rec.opcode : '0;
        draw     = rec.is_type3 && (op inside {OP_DRAW_INDX, OP_DRAW_INDX_BIN,
                                               OP_DRAW_INDX_IMM, OP_DRAW_INDX_2,
                                               OP_DRAW_INDX_OFS});
        has_init = 1'b0;
        init     = '0;
        if (rec.is_type3 && op == OP_DRAW_INDX) begin
            has_init = 1'b1;
            init     = rec.words[1];
        end
        if (rec.is_type3 && op == OP_DRAW_INDX_2) begin
            has_init = 1'b1;
            init     = rec.words[0];
        end
        if (!has_init) begin
            init = '0;
        end
        data_next = {4'b0,
                     init[31:10],
                     init[7:6],
                     init[5:0],
                     rec.words[3],
                     rec.words[2],
                     rec.words[1],
                     rec.words[0],
                     draw,
                     rec.data_count,
                     op,
                     rec.kind,
                     rec.packet_offset};
    end

    // Load when the register is empty or being taken
    assign load       = rec_valid && (!valid_reg || m_tready);
    assign rec_pop    = load;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

`default_nettype wire
